@@ hw/rtl/gdg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gdg_pkg;

   // Output cap and counter widths.
   localparam int MAX_DIGITS = 20;
   localparam int CNT_W      = 6;
   localparam int PC_W       = 3;

   // Split-point limits for the binary exponent.
   localparam logic [5:0] SHIFT_MIN = 6'd32;
   localparam logic [5:0] SHIFT_MAX = 6'd60;

   // ASCII code of the digit zero.
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // Program addresses of the digit sequencer.
   localparam logic [PC_W-1:0] PC_IDLE       = 3'd0;
   localparam logic [PC_W-1:0] PC_DIV_STEP   = 3'd1;
   localparam logic [PC_W-1:0] PC_INT_DIGIT  = 3'd2;
   localparam logic [PC_W-1:0] PC_DIV_INIT   = 3'd3;
   localparam logic [PC_W-1:0] PC_FRAC_MUL   = 3'd4;
   localparam logic [PC_W-1:0] PC_FRAC_DIGIT = 3'd5;
   localparam logic [PC_W-1:0] PC_FINISH     = 3'd6;

   // Datapath operation selected by one control word.
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_DIV_STEP,
      OP_INT_DIGIT,
      OP_DIV_INIT,
      OP_FRAC_MUL,
      OP_FRAC_DIGIT,
      OP_FINISH
   } op_type;

   // Jump condition of one control word.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_BIT_LEFT,
      COND_STOP,
      COND_NOT_STOP,
      COND_MORE_INT
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } ucode_type;

   // Datapath flags that the sequencer branches on.
   typedef struct packed {
      logic start;
      logic bit_left;
      logic stop;
      logic more_int;
   } status_type;

   // Control store: one word per program step.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type word;
      case (pc)
         PC_IDLE:       word = '{op: OP_LOAD,       cond: COND_NO_START, target: PC_IDLE};
         PC_DIV_STEP:   word = '{op: OP_DIV_STEP,   cond: COND_BIT_LEFT, target: PC_DIV_STEP};
         PC_INT_DIGIT:  word = '{op: OP_INT_DIGIT,  cond: COND_STOP,     target: PC_FINISH};
         PC_DIV_INIT:   word = '{op: OP_DIV_INIT,   cond: COND_MORE_INT, target: PC_DIV_STEP};
         PC_FRAC_MUL:   word = '{op: OP_FRAC_MUL,   cond: COND_NEVER,    target: PC_IDLE};
         PC_FRAC_DIGIT: word = '{op: OP_FRAC_DIGIT, cond: COND_NOT_STOP, target: PC_FRAC_MUL};
         PC_FINISH:     word = '{op: OP_FINISH,     cond: COND_ALWAYS,   target: PC_IDLE};
         default:       word = '{op: OP_FINISH,     cond: COND_ALWAYS,   target: PC_IDLE};
      endcase
      return word;
   endfunction

   // Powers of ten used as divisors of the integer part.
   function automatic logic [31:0] pow10(input logic [3:0] n);
      logic [31:0] value;
      case (n)
         4'd0:    value = 32'd1;
         4'd1:    value = 32'd10;
         4'd2:    value = 32'd100;
         4'd3:    value = 32'd1000;
         4'd4:    value = 32'd10000;
         4'd5:    value = 32'd100000;
         4'd6:    value = 32'd1000000;
         4'd7:    value = 32'd10000000;
         4'd8:    value = 32'd100000000;
         4'd9:    value = 32'd1000000000;
         default: value = 32'd0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gdg_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gdg_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gdg_pkg::status_type   status,
   output logic                       busy,
   output gdg_pkg::op_type            op
);

   logic [gdg_pkg::PC_W-1:0] pc_ff;
   logic [gdg_pkg::PC_W-1:0] pc_in;
   gdg_pkg::ucode_type       word;
   logic                     jump;

   // Fetch the control word of the current step.
   assign word = gdg_pkg::ucode_rom(pc_ff);
   assign op   = word.op;
   assign busy = (pc_ff != gdg_pkg::PC_IDLE);

   // Evaluate the jump condition and pick the next step.
   always_comb begin
      case (word.cond)
         gdg_pkg::COND_NEVER:    jump = 1'b0;
         gdg_pkg::COND_ALWAYS:   jump = 1'b1;
         gdg_pkg::COND_NO_START: jump = !status.start;
         gdg_pkg::COND_BIT_LEFT: jump = status.bit_left;
         gdg_pkg::COND_STOP:     jump = status.stop;
         gdg_pkg::COND_NOT_STOP: jump = !status.stop;
         gdg_pkg::COND_MORE_INT: jump = status.more_int;
         default:                jump = 1'b1;
      endcase
      pc_in = jump ? word.target : pc_ff + 1'b1;
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= gdg_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/grisu_digit_generation_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Grisu2 digit generation. A request is taken when start is high and busy is
// low; busy then stays high until the final result has been written. Results
// leave one per rsp_strobe pulse and cannot be held off, so a receiver must
// take every pulse. At most ten integer-part positions are examined. Each
// integer position takes four restoring divide steps of one bit each plus two
// sequencer steps, the second of which is skipped when generation stops there,
// and each fraction position (leading zeros included) takes a multiply-by-ten
// step and a digit step. Digits come out one position late: a digit is held
// until the next digit pushes it out, or until the finish step that follows
// the last stop check writes it as the final result, which appears in the
// first cycle with busy low.
module grisu_digit_generation_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [63:0]        req_upper_significand,
   input  wire logic signed [6:0]  req_binary_exponent,
   input  wire logic [63:0]        req_delta_significand,
   input  wire logic signed [9:0]  req_decimal_exponent_in,
   output logic                    rsp_strobe,
   output logic [5:0]              rsp_ascii_digit,
   output logic                    rsp_digit_present,
   output logic                    rsp_last_digit,
   output logic signed [9:0]       rsp_decimal_exponent_out,
   output logic [5:0]              rsp_digit_count,
   output logic                    rsp_truncated
);

   gdg_pkg::op_type     op;
   gdg_pkg::status_type status;

   // Working registers.
   logic [5:0]                 s_ff, s_in;
   logic [63:0]                mask_ff, mask_in;
   logic [31:0]                p1_ff, p1_in;
   logic [63:0]                p2_ff, p2_in;
   logic [63:0]                delta_ff, delta_in;
   logic [31:0]                dh_ff, dh_in;
   logic [63:0]                dl_ff, dl_in;
   logic signed [9:0]          kin_ff, kin_in;
   logic signed [6:0]          kappa_ff, kappa_in;
   logic [3:0]                 q_ff, q_in;
   logic [1:0]                 j_ff, j_in;
   logic [gdg_pkg::CNT_W-1:0]  len_ff, len_in;
   logic                       trunc_ff, trunc_in;
   logic [3:0]                 pend_ff, pend_in;
   logic                       pend_v_ff, pend_v_in;

   // Result registers.
   logic                       strobe_ff, strobe_in;
   logic [5:0]                 ascii_ff, ascii_in;
   logic                       present_ff, present_in;
   logic                       last_ff, last_in;
   logic signed [9:0]          dexp_ff, dexp_in;
   logic [5:0]                 count_ff, count_in;
   logic                       rtrunc_ff, rtrunc_in;

   // Intermediate values.
   logic signed [6:0]          neg_e;
   logic [5:0]                 s_load;
   logic [63:0]                mask_load;
   logic signed [6:0]          kappa_m1;
   logic [34:0]                trial;
   logic [63:0]                frac_shift;
   logic [63:0]                p2_masked;
   logic                       int_within;
   logic                       frac_within;
   logic                       within_now;
   logic [3:0]                 digit_now;
   logic                       emit;
   logic [gdg_pkg::CNT_W-1:0]  len_next;
   logic                       cap_hit;
   logic signed [10:0]         dexp_sum;
   logic signed [9:0]          dexp_sat;

   gdg_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .busy   (busy),
      .op     (op)
   );

   // Split point from the saturated binary exponent.
   always_comb begin
      neg_e = -req_binary_exponent;
      if (req_binary_exponent < -7'sd60) begin
         s_load = gdg_pkg::SHIFT_MAX;
      end else if (req_binary_exponent > -7'sd32) begin
         s_load = gdg_pkg::SHIFT_MIN;
      end else begin
         s_load = neg_e[5:0];
      end
      mask_load = (64'd1 << s_load) - 64'd1;
   end

   // Divisor trial for the current bit of the integer digit.
   assign kappa_m1 = kappa_ff - 7'sd1;
   assign trial    = {3'b000, gdg_pkg::pow10(kappa_m1[3:0])} << j_ff;

   // Stop checks: remainder within the window.
   assign int_within  = (p1_ff < dh_ff) || ((p1_ff == dh_ff) && (p2_ff <= dl_ff));
   assign frac_shift  = p2_ff >> s_ff;
   assign p2_masked   = p2_ff & mask_ff;
   assign frac_within = (p2_masked <= delta_ff);

   // Digit produced in this step and its effect on the count.
   always_comb begin
      if (op == gdg_pkg::OP_FRAC_DIGIT) begin
         digit_now  = frac_shift[3:0];
         within_now = frac_within;
      end else begin
         digit_now  = q_ff;
         within_now = int_within;
      end
      emit     = (digit_now != 4'd0) || (len_ff != '0);
      len_next = len_ff + {{(gdg_pkg::CNT_W-1){1'b0}}, emit};
      cap_hit  = (len_next >= gdg_pkg::CNT_W'(gdg_pkg::MAX_DIGITS));
   end

   // Adjusted decimal exponent, saturated to the output range.
   always_comb begin
      dexp_sum = 11'(kin_ff) + 11'(kappa_ff);
      if (dexp_sum < -11'sd512) begin
         dexp_sat = -10'sd512;
      end else if (dexp_sum > 11'sd511) begin
         dexp_sat = 10'sd511;
      end else begin
         dexp_sat = dexp_sum[9:0];
      end
   end

   // Flags for the sequencer.
   always_comb begin
      status.start    = start;
      status.bit_left = (j_ff != 2'd0);
      status.stop     = within_now || cap_hit;
      status.more_int = (kappa_ff != 7'sd0);
   end

   // Datapath next-state logic under control of the current step.
   always_comb begin
      s_in       = s_ff;
      mask_in    = mask_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      delta_in   = delta_ff;
      dh_in      = dh_ff;
      dl_in      = dl_ff;
      kin_in     = kin_ff;
      kappa_in   = kappa_ff;
      q_in       = q_ff;
      j_in       = j_ff;
      len_in     = len_ff;
      trunc_in   = trunc_ff;
      pend_in    = pend_ff;
      pend_v_in  = pend_v_ff;
      strobe_in  = 1'b0;
      ascii_in   = ascii_ff;
      present_in = present_ff;
      last_in    = last_ff;
      dexp_in    = dexp_ff;
      count_in   = count_ff;
      rtrunc_in  = rtrunc_ff;

      case (op)
         gdg_pkg::OP_LOAD: begin
            if (start) begin
               s_in      = s_load;
               mask_in   = mask_load;
               p1_in     = 32'(req_upper_significand >> s_load);
               p2_in     = req_upper_significand & mask_load;
               delta_in  = req_delta_significand;
               dh_in     = 32'(req_delta_significand >> s_load);
               dl_in     = req_delta_significand & mask_load;
               kin_in    = req_decimal_exponent_in;
               kappa_in  = 7'sd10;
               q_in      = 4'd0;
               j_in      = 2'd3;
               len_in    = '0;
               trunc_in  = 1'b0;
               pend_v_in = 1'b0;
            end
         end

         // One restoring divide step on the integer part.
         gdg_pkg::OP_DIV_STEP: begin
            if ({3'b000, p1_ff} >= trial) begin
               p1_in     = p1_ff - trial[31:0];
               q_in[j_ff] = 1'b1;
            end
            j_in = j_ff - 2'd1;
         end

         gdg_pkg::OP_DIV_INIT: begin
            q_in = 4'd0;
            j_in = 2'd3;
         end

         // Multiply remainder and window by ten; the window wraps.
         gdg_pkg::OP_FRAC_MUL: begin
            p2_in    = (p2_ff << 3) + (p2_ff << 1);
            delta_in = (delta_ff << 3) + (delta_ff << 1);
         end

         gdg_pkg::OP_INT_DIGIT,
         gdg_pkg::OP_FRAC_DIGIT: begin
            kappa_in = kappa_ff - 7'sd1;
            len_in   = len_next;
            trunc_in = !within_now && cap_hit;
            if (op == gdg_pkg::OP_FRAC_DIGIT) begin
               p2_in = p2_masked;
            end
            // A new digit pushes the held one out as a non-final result.
            if (emit) begin
               if (pend_v_ff) begin
                  strobe_in  = 1'b1;
                  ascii_in   = gdg_pkg::ASCII_ZERO + {2'b00, pend_ff};
                  present_in = 1'b1;
                  last_in    = 1'b0;
                  dexp_in    = '0;
                  count_in   = '0;
                  rtrunc_in  = 1'b0;
               end
               pend_in   = digit_now;
               pend_v_in = 1'b1;
            end
         end

         // Final result: the held digit, or an empty result.
         gdg_pkg::OP_FINISH: begin
            strobe_in  = 1'b1;
            last_in    = 1'b1;
            dexp_in    = dexp_sat;
            if (pend_v_ff) begin
               ascii_in   = gdg_pkg::ASCII_ZERO + {2'b00, pend_ff};
               present_in = 1'b1;
               count_in   = 6'(len_ff);
               rtrunc_in  = trunc_ff;
            end else begin
               ascii_in   = '0;
               present_in = 1'b0;
               count_in   = '0;
               rtrunc_in  = 1'b0;
            end
            pend_v_in = 1'b0;
         end

         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         pend_v_ff <= pend_v_in;
      end
   end

   // Datapath and result payload registers.
   always_ff @(posedge clock) begin
      s_ff       <= s_in;
      mask_ff    <= mask_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      delta_ff   <= delta_in;
      dh_ff      <= dh_in;
      dl_ff      <= dl_in;
      kin_ff     <= kin_in;
      kappa_ff   <= kappa_in;
      q_ff       <= q_in;
      j_ff       <= j_in;
      len_ff     <= len_in;
      trunc_ff   <= trunc_in;
      pend_ff    <= pend_in;
      ascii_ff   <= ascii_in;
      present_ff <= present_in;
      last_ff    <= last_in;
      dexp_ff    <= dexp_in;
      count_ff   <= count_in;
      rtrunc_ff  <= rtrunc_in;
   end

   assign rsp_strobe               = strobe_ff;
   assign rsp_ascii_digit          = ascii_ff;
   assign rsp_digit_present        = present_ff;
   assign rsp_last_digit           = last_ff;
   assign rsp_decimal_exponent_out = dexp_ff;
   assign rsp_digit_count          = count_ff;
   assign rsp_truncated            = rtrunc_ff;

   // An accepted request makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // The block goes idle only together with the final result.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_last_digit))
      else $error("block went idle without a final result");

   // Non-final results always carry a digit and no summary.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_digit) |-> (rsp_digit_present && (rsp_digit_count == 6'd0)))
      else $error("non-final result without digit or with a count");

   // The count on a final result matches presence and respects the cap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_digit) |->
         ((rsp_digit_present == (rsp_digit_count != 6'd0)) &&
          (rsp_digit_count <= 6'(gdg_pkg::MAX_DIGITS))))
      else $error("final result count inconsistent");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_ITEMS = 354;
   localparam int NUM_ROWS     = 16;
   localparam int STALL_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 200;

   // One digit result as it appears on the response ports.
   typedef struct packed {
      logic [5:0]        ascii;
      logic              present;
      logic              last;
      logic signed [9:0] dexp;
      logic [5:0]        count;
      logic              trunc;
   } digit_result_type;

   // One directed request; typed rows carry their single result written out.
   typedef struct packed {
      logic [63:0]       upper;
      logic signed [6:0] bexp;
      logic [63:0]       delta;
      logic signed [9:0] kexp;
      logic              typed;
      digit_result_type  want;
   } request_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [63:0]       req_upper_significand = '0;
   logic signed [6:0] req_binary_exponent = '0;
   logic [63:0]       req_delta_significand = '0;
   logic signed [9:0] req_decimal_exponent_in = '0;
   logic              rsp_strobe;
   logic [5:0]        rsp_ascii_digit;
   logic              rsp_digit_present;
   logic              rsp_last_digit;
   logic signed [9:0] rsp_decimal_exponent_out;
   logic [5:0]        rsp_digit_count;
   logic              rsp_truncated;

   digit_result_type  expected_digits[$];
   logic              use_row_want = 1'b0;
   digit_result_type  row_want = '0;
   int                mismatches = 0;
   int                quiet_cycles = 0;

   // Directed requests: empty output, exponent saturation, the digit cap, leading
   // fraction zeros, out-of-range binary exponents and a wrapping window.
   request_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{64'h0, -7'sd32, 64'h0, 10'sd0, 1'b1,
        '{6'd0, 1'b0, 1'b1, 10'sd9, 6'd0, 1'b0}},
      '{64'h0, -7'sd32, 64'h0, 10'sd511, 1'b1,
        '{6'd0, 1'b0, 1'b1, 10'sd511, 6'd0, 1'b0}},
      '{64'h1, -7'sd60, 64'hFFFF_FFFF_FFFF_FFFF, 10'h200, 1'b1,
        '{6'd0, 1'b0, 1'b1, -10'sd503, 6'd0, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, -7'sd32, 64'hFFFF_FFFF_FFFF_FFFF, 10'sd0, 1'b1,
        '{6'd52, 1'b1, 1'b1, 10'sd9, 6'd1, 1'b0}},
      '{64'h3B9A_CA00_0000_0000, -7'sd32, 64'h0, 10'sd0, 1'b1,
        '{6'd49, 1'b1, 1'b1, 10'sd9, 6'd1, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, -7'sd32, 64'h0, 10'sd0, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FFFF, -7'sd60, 64'h0, 10'h200, 1'b0, '0},
      '{64'h1, -7'sd60, 64'h0, 10'sd0, 1'b0, '0},
      '{64'h8000_0000_0000_0000, -7'sd60, 64'h1, 10'sd0, 1'b0, '0},
      '{64'h0123_4567_89AB_CDEF, 7'h40, 64'h0000_0000_0001_0000, 10'sd100, 1'b0, '0},
      '{64'h0123_4567_89AB_CDEF, 7'h3F, 64'h0000_0000_0001_0000, 10'sd100, 1'b0, '0},
      '{64'hFEDC_BA98_7654_3210, 7'h00, 64'h0000_0100_0000_0000, -10'sd100, 1'b0, '0},
      '{64'h0FFF_FFFF_FFFF_FFFF, -7'sd60, 64'h4000_0000_0000_0000, 10'sd0, 1'b0, '0},
      '{64'hE3B2_5F1A_9C40_7D11, -7'sd45, 64'h0000_0000_0400_0000, -10'sd400, 1'b0, '0},
      '{64'h9A31_C2D8_04F7_B6E5, -7'sd33, 64'h0000_0000_0000_0800, 10'sd400, 1'b0, '0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 7'h43, 64'h0000_0000_0000_5555, 10'sd7, 1'b0, '0}
   };

   grisu_digit_generation_core dut (
      .clock                    (clock),
      .reset                    (reset),
      .start                    (start),
      .busy                     (busy),
      .req_upper_significand    (req_upper_significand),
      .req_binary_exponent      (req_binary_exponent),
      .req_delta_significand    (req_delta_significand),
      .req_decimal_exponent_in  (req_decimal_exponent_in),
      .rsp_strobe               (rsp_strobe),
      .rsp_ascii_digit          (rsp_ascii_digit),
      .rsp_digit_present        (rsp_digit_present),
      .rsp_last_digit           (rsp_last_digit),
      .rsp_decimal_exponent_out (rsp_decimal_exponent_out),
      .rsp_digit_count          (rsp_digit_count),
      .rsp_truncated            (rsp_truncated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the digit results of one request and queues them in order.
   task automatic predict_digits(input logic [63:0] upper, input logic signed [6:0] bexp,
                                 input logic [63:0] delta_in, input logic signed [9:0] kexp);
      logic [63:0]      frac;
      logic [63:0]      mask;
      logic [63:0]      delta;
      logic [31:0]      int_part;
      logic [31:0]      divisor;
      logic [3:0]       digit_buf [gdg_pkg::MAX_DIGITS];
      logic [3:0]       dig;
      int               shift;
      int               len;
      int               kappa;
      int               dexp;
      bit               done;
      bit               trunc;
      digit_result_type r;

      // The split point is the saturated binary exponent.
      shift = -int'(bexp);
      if (shift > 60) shift = 60;
      if (shift < 32) shift = 32;
      mask = (64'd1 << shift) - 64'd1;
      int_part = 32'(upper >> shift);
      frac = upper & mask;
      delta = delta_in;
      divisor = 32'd1000000000;
      len = 0;
      kappa = 10;
      done = 1'b0;
      trunc = 1'b0;

      // Integer part: divide by falling powers of ten, skipping leading zeros.
      while (kappa > 0 && !done) begin
         dig = 4'(int_part / divisor);
         if (dig != 4'd0 || len != 0) begin
            digit_buf[len] = dig;
            len++;
         end
         int_part = int_part % divisor;
         kappa--;
         divisor = divisor / 32'd10;
         if ((64'(int_part) << shift) + frac <= delta) begin
            done = 1'b1;
         end else if (len >= gdg_pkg::MAX_DIGITS) begin
            done = 1'b1;
            trunc = 1'b1;
         end
      end

      // Fraction: scale by ten together with the window, which wraps at 64 bits.
      while (!done) begin
         frac = frac * 64'd10;
         dig = 4'(frac >> shift);
         if (dig != 4'd0 || len != 0) begin
            digit_buf[len] = dig;
            len++;
         end
         frac = frac & mask;
         kappa--;
         delta = delta * 64'd10;
         if (frac <= delta) begin
            done = 1'b1;
         end else if (len >= gdg_pkg::MAX_DIGITS) begin
            done = 1'b1;
            trunc = 1'b1;
         end
      end

      dexp = int'(kexp) + kappa;
      if (dexp < -512) dexp = -512;
      if (dexp > 511) dexp = 511;

      if (len == 0) begin
         r = '{6'd0, 1'b0, 1'b1, 10'(dexp), 6'd0, 1'b0};
         expected_digits.push_back(r);
      end else begin
         for (int k = 0; k < len; k++) begin
            r = '0;
            r.ascii = gdg_pkg::ASCII_ZERO + 6'(digit_buf[k]);
            r.present = 1'b1;
            if (k == len - 1) begin
               r.last = 1'b1;
               r.dexp = 10'(dexp);
               r.count = 6'(len);
               r.trunc = trunc;
            end
            expected_digits.push_back(r);
         end
      end
   endtask

   task automatic check_field(input string name, input logic signed [10:0] want_v,
                              input logic signed [10:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // Request capture and result checking, both on the rising edge.
   always @(posedge clock) begin
      digit_result_type want;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_strobe) begin
            quiet_cycles = 0;
            if (expected_digits.size() == 0) begin
               $error("digit result with none outstanding");
               mismatches++;
            end else begin
               want = expected_digits.pop_front();
               check_field("ascii_digit", want.ascii, rsp_ascii_digit);
               check_field("digit_present", want.present, rsp_digit_present);
               check_field("last_digit", want.last, rsp_last_digit);
               check_field("decimal_exponent_out", want.dexp, rsp_decimal_exponent_out);
               check_field("digit_count", want.count, rsp_digit_count);
               check_field("truncated", want.trunc, rsp_truncated);
            end
         end
         if (start && !busy) begin
            quiet_cycles = 0;
            if (use_row_want)
               expected_digits.push_back(row_want);
            else
               predict_digits(req_upper_significand, req_binary_exponent,
                              req_delta_significand, req_decimal_exponent_in);
         end
      end
   end

   // Watchdog: too long without a request or a result taken ends the run.
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // Presents one request from a falling edge and holds it until it is taken.
   task automatic send_request(input logic [63:0] upper, input logic signed [6:0] bexp,
                               input logic [63:0] delta, input logic signed [9:0] kexp,
                               input logic typed, input digit_result_type want);
      req_upper_significand = upper;
      req_binary_exponent = bexp;
      req_delta_significand = delta;
      req_decimal_exponent_in = kexp;
      use_row_want = typed;
      row_want = want;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Sender gaps: mostly none or short, now and then a long one.
   task automatic idle_sender(input bit quiet);
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55)
         gap = 0;
      else if (roll < 85)
         gap = $urandom_range(1, 3);
      else if (roll < 96)
         gap = $urandom_range(4, 15);
      else
         gap = $urandom_range(30, 90);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start = 1'b0;
      while (expected_digits.size() != 0) @(negedge clock);
   endtask

   // Random requests, mostly shaped like real conversions.
   task automatic make_random_request(output logic [63:0] upper,
                                      output logic signed [6:0] bexp,
                                      output logic [63:0] delta,
                                      output logic signed [9:0] kexp);
      int          kind;
      logic [63:0] noise;
      kind = $urandom_range(0, 99);
      noise = {$urandom, $urandom};
      upper = {$urandom, $urandom};
      bexp = 7'(-$urandom_range(32, 60));
      kexp = 10'($urandom_range(0, 800) - 400);
      if (kind < 60) begin
         // Normalized boundary with a window of random magnitude.
         upper[63] = 1'b1;
         delta = noise >> $urandom_range(8, 63);
      end else if (kind < 70) begin
         // Almost no window, so the digit cap is reached.
         delta = 64'($urandom_range(0, 3));
      end else if (kind < 78) begin
         // Window covering the boundary: few or no digits.
         delta = upper | noise;
      end else if (kind < 90) begin
         // Unconstrained fields, exponents outside their usual ranges included.
         bexp = 7'($urandom);
         kexp = 10'($urandom);
         delta = noise >> $urandom_range(0, 63);
      end else begin
         // Small boundary: leading zeros in the fraction.
         upper = upper >> $urandom_range(20, 63);
         delta = noise >> $urandom_range(30, 63);
      end
   endtask

   initial begin
      logic [63:0]       upper;
      logic signed [6:0] bexp;
      logic [63:0]       delta;
      logic signed [9:0] kexp;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_request(directed_rows[i].upper, directed_rows[i].bexp, directed_rows[i].delta,
                      directed_rows[i].kexp, directed_rows[i].typed, directed_rows[i].want);
         idle_sender(1'b0);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         make_random_request(upper, bexp, delta, kexp);
         send_request(upper, bexp, delta, kexp, 1'b0, '0);
         // Hold the sender off twice until every pending result is out.
         if (n == 120 || n == 260)
            wait_for_drain();
         else
            idle_sender((n % 64) < 16);
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/gdg_pkg.sv
hw/rtl/gdg_sequencer.sv
hw/rtl/grisu_digit_generation_core.sv
sim/tb_top.sv
